// ===== rtl/mvmb_pkg.sv =====
`default_nettype none
package mvmb_pkg;
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ACT    = 2'd2;

  localparam logic [2:0] REG_COLS  = 3'd0;
  localparam logic [2:0] REG_OUTS  = 3'd1;
  localparam logic [2:0] REG_ROWS  = 3'd2;
  localparam logic [2:0] REG_BIAS  = 3'd3;
  localparam logic [2:0] REG_TRANS = 3'd4;

  localparam int ACC_W = 40;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  out_index;
    logic signed [39:0] out_value;
    logic        row_last;
    logic        matrix_done;
  } out_item_t;

  // row job handed from front to back
  typedef struct packed {
    logic [6:0] ncols;
    logic [6:0] nouts;
    logic       last_row;
    logic       bias_en;
    logic       trans;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/mvmb_front.sv =====
`default_nettype none
// Accepts transactions, writes stores, issues a job on a row's last column.
module mvmb_front #(
  parameter int MAX_INNER = 64
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  mvmb_pkg::in_item_t item,
  input  wire  take,
  input  wire  [6:0]  cols_in_use,
  input  wire  [6:0]  rows_out,
  input  wire  [10:0] rows_in_matrix,
  input  wire  bias_enable,
  input  wire  weights_transposed,
  output logic w_we,
  output logic [11:0] w_addr,
  output logic b_we,
  output logic a_we,
  output logic job_valid,
  output mvmb_pkg::job_t job
);
  import mvmb_pkg::*;
  // inner length is capped by MAX_INNER and by the 64-entry row buffer
  localparam logic [6:0] INNER_CAP = 7'((MAX_INNER < 64) ? MAX_INNER : 64);

  logic [9:0] row_counter;
  logic [6:0] ncols, nouts;
  logic [10:0] nrows;
  logic last_row;

  always_comb begin
    ncols = (cols_in_use == 7'd0) ? 7'd1 :
            (cols_in_use > INNER_CAP ? INNER_CAP : cols_in_use);
    nouts = (rows_out == 7'd0) ? 7'd1 : (rows_out > 7'd64 ? 7'd64 : rows_out);
    nrows = (rows_in_matrix == 11'd0) ? 11'd1 :
            (rows_in_matrix > 11'd1024 ? 11'd1024 : rows_in_matrix);
    last_row = {1'b0, row_counter} >= (nrows - 11'd1);
    w_we = take && item.cmd == CMD_WEIGHT;
    w_addr = {item.row_index, item.col_index};
    b_we = take && item.cmd == CMD_BIAS;
    a_we = take && item.cmd == CMD_ACT;
    job_valid = a_we && ({1'b0, item.col_index} == ncols - 7'd1);
    job = '{ncols: ncols, nouts: nouts, last_row: last_row,
            bias_en: bias_enable, trans: weights_transposed};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
    end else if (job_valid) begin
      row_counter <= last_row ? 10'd0 : row_counter + 10'd1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mvmb_back.sv =====
`default_nettype none
// One MAC: per output, bias then ncols products, result into a 2-deep FIFO.
module mvmb_back (
  input  wire  clk,
  input  wire  rst,
  input  wire  mvmb_pkg::in_item_t item,
  input  wire  w_we,
  input  wire  [11:0] w_addr,
  input  wire  b_we,
  input  wire  a_we,
  input  wire  job_valid,
  input  wire  mvmb_pkg::job_t job_in,
  output logic busy,
  output logic empty,
  input  wire  pop,
  output mvmb_pkg::out_item_t result
);
  import mvmb_pkg::*;
  logic signed [15:0] wmem [4096];
  logic signed [15:0] bmem [64];
  logic signed [15:0] amem [64];
  logic signed [15:0] w_q, a_q, b_q;

  job_t job;
  logic running, rd_v, mul_v, fin;
  logic [5:0] j, k;
  logic rd_last, mul_last;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic first_rd, first_mul;

  out_item_t fifo [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic out_ok;

  // issue: hold until the FIFO is empty before each output (pipe depth small)
  assign out_ok = (cnt == 2'd0);
  assign busy = running || rd_v || mul_v || fin;

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_addr] <= item.value;
    if (b_we) bmem[item.row_index] <= item.value;
    if (a_we) amem[item.col_index] <= item.value;
    w_q <= wmem[job.trans ? {j, k} : {k, j}];
    a_q <= amem[k];
    b_q <= bmem[j];
    prod <= a_q * w_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0; rd_v <= 1'b0; mul_v <= 1'b0; fin <= 1'b0;
      j <= '0; k <= '0;
    end else begin
      rd_v <= 1'b0;
      if (job_valid && !busy) begin
        job <= job_in; running <= 1'b1; j <= '0; k <= '0;
      end else if (running && out_ok && !fin && !mul_v && !rd_v || running && k != 6'd0) begin
        rd_v <= 1'b1;
        first_rd <= (k == 6'd0);
        rd_last <= ({1'b0, k} == job.ncols - 7'd1);
        if ({1'b0, k} == job.ncols - 7'd1) begin
          k <= '0;
          running <= 1'b0;
        end else begin
          k <= k + 6'd1;
        end
      end
      mul_v <= rd_v;
      first_mul <= first_rd;
      mul_last <= rd_last;
      if (mul_v) begin
        acc <= (first_mul ? (job.bias_en ? ACC_W'(b_q) <<< 12 : '0) : acc)
               + ACC_W'(prod);
      end
      fin <= mul_v && mul_last;
      if (fin) begin
        if ({1'b0, j} != job.nouts - 7'd1) begin
          j <= j + 6'd1; running <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) fifo[wp] <= '{out_index: j, out_value: acc,
                           row_last: {1'b0, j} == job.nouts - 7'd1,
                           matrix_done: ({1'b0, j} == job.nouts - 7'd1) && job.last_row};
    if (rst) begin
      cnt <= '0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (fin) wp <= ~wp;
      if (pop && cnt != 2'd0) rp <= ~rp;
      cnt <= cnt + {1'b0, fin} - {1'b0, pop && cnt != 2'd0};
    end
  end

  assign empty = (cnt == 2'd0);
  assign result = fifo[rp];
endmodule
`default_nettype wire

// ===== rtl/matrix_vector_multiply_bias.sv =====
`default_nettype none
// Channel | direction | handshake       | payload
// in      | in        | push / full     | mvmb_pkg::in_item_t
// out     | out       | pop / empty     | mvmb_pkg::out_item_t
// cfg     | in        | cfg_valid/ready | cfg_index, cfg_data
// Loads and non-last activations are written as they are taken. A row's last
// column starts a job of rows_out outputs, each passing through the single
// MAC and the weight memory read port; full stays high until it finishes.
// Each result waits in a two-entry queue; an untaken result holds the MAC.
// Reset (rst, synchronous) clears the row counter and sets the config registers
// to their defaults; stores are undefined until written.
module matrix_vector_multiply_bias #(
  parameter int MAX_INNER = 64
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  output logic full,
  input  wire  mvmb_pkg::in_item_t in_item,
  output logic empty,
  input  wire  pop,
  output mvmb_pkg::out_item_t out_item,
  input  wire  cfg_valid,
  output logic cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [10:0] cfg_data
);
  import mvmb_pkg::*;
  logic [6:0] cols_in_use, rows_out;
  logic [10:0] rows_in_matrix;
  logic bias_enable, weights_transposed;
  logic take, busy, w_we, b_we, a_we, job_valid, a_ok;
  logic [11:0] w_addr;
  job_t job;

  assign cfg_ready = 1'b1;
  assign full = busy;
  assign take = push && !full;
  // activations beyond MAX_INNER are dropped
  assign a_ok = {26'd0, in_item.col_index} < 32'(MAX_INNER);

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= 7'd64; rows_out <= 7'd64; rows_in_matrix <= 11'd1;
      bias_enable <= 1'b0; weights_transposed <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLS:  cols_in_use <= cfg_data[6:0];
        REG_OUTS:  rows_out <= cfg_data[6:0];
        REG_ROWS:  rows_in_matrix <= cfg_data;
        REG_BIAS:  bias_enable <= cfg_data[0];
        REG_TRANS: weights_transposed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mvmb_front #(.MAX_INNER(MAX_INNER)) u_front (
    .clk, .rst, .item(in_item), .take(take && (in_item.cmd != CMD_ACT || a_ok)),
    .cols_in_use, .rows_out, .rows_in_matrix, .bias_enable, .weights_transposed,
    .w_we, .w_addr, .b_we, .a_we, .job_valid, .job
  );

  mvmb_back u_back (
    .clk, .rst, .item(in_item), .w_we, .w_addr, .b_we, .a_we,
    .job_valid, .job_in(job), .busy, .empty, .pop, .result(out_item)
  );
endmodule
`default_nettype wire

// ===== test/matrix_vector_multiply_bias_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module matrix_vector_multiply_bias_tb;
  import mvmb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  matrix_vector_multiply_bias dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block: stores, row counter and registers.
  logic signed [15:0] wgt_mem [64][64];
  logic signed [15:0] bias_mem [64];
  logic signed [15:0] act_mem [64];
  logic [9:0]  row_cnt;
  logic [6:0]  ncols_reg, nouts_reg;
  logic [10:0] nrows_reg;
  logic        bias_on, trans_on;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int  send_idle, recv_idle;   // idle odds per hundred
  bit  failed;
  int  n_items, n_results, n_rows;

  // Work out the results caused by one accepted input transaction.
  task automatic compute_row_results(input in_item_t it);
    logic [39:0] acc;
    logic signed [31:0] prod;
    logic signed [15:0] w;
    int nc, no, nr;
    bit last_row;
    out_item_t r;
    case (it.cmd)
      CMD_WEIGHT: wgt_mem[it.row_index][it.col_index] = it.value;
      CMD_BIAS:   bias_mem[it.row_index] = it.value;
      CMD_ACT: begin
        act_mem[it.col_index] = it.value;
        nc = (ncols_reg < 1) ? 1 : (ncols_reg > 64) ? 64 : ncols_reg;
        if (it.col_index == nc - 1) begin
          no = (nouts_reg < 1) ? 1 : (nouts_reg > 64) ? 64 : nouts_reg;
          nr = (nrows_reg < 1) ? 1 : (nrows_reg > 1024) ? 1024 : nrows_reg;
          last_row = (row_cnt >= nr - 1);
          for (int j = 0; j < no; j++) begin
            acc = bias_on ? 40'(signed'(bias_mem[j])) << 12 : '0;
            for (int k = 0; k < nc; k++) begin
              w = trans_on ? wgt_mem[j][k] : wgt_mem[k][j];
              prod = act_mem[k] * w;
              acc = acc + 40'(prod);
            end
            r.out_index = j[5:0];
            r.out_value = acc;
            r.row_last = (j == no - 1);
            r.matrix_done = (j == no - 1) && last_row;
            expected_results.push_back(r);
          end
          row_cnt = last_row ? '0 : row_cnt + 10'd1;
          n_rows++;
        end
      end
      default: ;  // unused command, ignored
    endcase
  endtask

  // Driver: one transaction per accepted push, gaps at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        compute_row_results(in_item);
        n_items++;
      end
      if (!(push && full)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          push <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (pop && !empty) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result index %0d", out_item.out_index);
          failed = 1'b1;
        end else begin
          e = expected_results.pop_front();
          if (out_item.out_index !== e.out_index) begin
            $error("out_index exp %0d got %0d", e.out_index, out_item.out_index);
            failed = 1'b1;
          end
          if (out_item.out_value !== e.out_value) begin
            $error("out_value exp %0d got %0d", e.out_value, out_item.out_value);
            failed = 1'b1;
          end
          if (out_item.row_last !== e.row_last) begin
            $error("row_last exp %0b got %0b", e.row_last, out_item.row_last);
            failed = 1'b1;
          end
          if (out_item.matrix_done !== e.matrix_done) begin
            $error("matrix_done exp %0b got %0b", e.matrix_done, out_item.matrix_done);
            failed = 1'b1;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Register write over the config channel; only called with the block idle.
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COLS:  ncols_reg = val[6:0];
      REG_OUTS:  nouts_reg = val[6:0];
      REG_ROWS:  nrows_reg = val;
      REG_BIAS:  bias_on = val[0];
      REG_TRANS: trans_on = val[0];
      default: ;
    endcase
  endtask

  task automatic setup(input int nc, input int no, input int nr,
                       input bit b, input bit t);
    write_reg(REG_COLS, 11'(nc));
    write_reg(REG_OUTS, 11'(no));
    write_reg(REG_ROWS, 11'(nr));
    write_reg(REG_BIAS, 11'(b));
    write_reg(REG_TRANS, 11'(t));
  endtask

  // Wait for all stimulus and results to drain, then a margin for the
  // MAC pipeline in case the last transaction produced nothing.
  task automatic drain();
    while (pending_items.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic in_item_t mk(input logic [1:0] c, input int r, input int k,
                                  input logic [15:0] v);
    in_item_t it;
    it.cmd = c; it.row_index = 6'(r); it.col_index = 6'(k); it.value = v;
    return it;
  endfunction

  // Load every weight and bias that a row with these sizes will read.
  task automatic queue_tables(input int nc, input int no, input bit t, input bit b,
                              input bit extreme);
    logic [15:0] v;
    for (int j = 0; j < no; j++)
      for (int k = 0; k < nc; k++) begin
        v = extreme ? (((j + k) & 1) ? 16'h8000 : 16'h7fff) : 16'($urandom);
        if (t) pending_items.push_back(mk(CMD_WEIGHT, j, k, v));
        else pending_items.push_back(mk(CMD_WEIGHT, k, j, v));
      end
    if (b)
      for (int j = 0; j < no; j++)
        pending_items.push_back(mk(CMD_BIAS, j, 0,
                                   extreme ? ((j & 1) ? 16'h8000 : 16'h7fff) : 16'($urandom)));
  endtask

  task automatic queue_row(input int nc, input bit extreme);
    for (int k = 0; k < nc; k++)
      pending_items.push_back(mk(CMD_ACT, $urandom_range(63), k,
                                 extreme ? ((k & 1) ? 16'h7fff : 16'h8000) : 16'($urandom)));
  endtask

  initial begin
    int nc, no, nr;
    bit b, t;
    failed = 1'b0;
    send_idle = 29; recv_idle = 67;
    row_cnt = '0; ncols_reg = 7'd64; nouts_reg = 7'd64; nrows_reg = 11'd1;
    bias_on = 1'b0; trans_on = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of operands, bias on and off, both weight layouts.
    setup(2, 2, 2, 1, 1);
    queue_tables(2, 2, 1, 1, 1);
    queue_row(2, 1);
    queue_row(2, 1);
    pending_items.push_back(mk(2'd3, 63, 63, 16'hffff));   // unused command
    drain();
    setup(3, 1, 1, 0, 0);
    queue_tables(3, 1, 0, 0, 1);
    pending_items.push_back(mk(CMD_ACT, 0, 5, 16'h1234));   // stored, not last
    queue_row(3, 1);
    drain();
    // Lower the matrix length under the row count: next row ends the matrix.
    setup(1, 1, 3, 0, 1);
    queue_tables(1, 1, 1, 0, 0);
    queue_row(1, 0);
    drain();
    write_reg(REG_ROWS, 11'd1);
    queue_row(1, 0);
    drain();
    // Most outputs per row; output count above 64 saturates, zero rows to one.
    setup(1, 100, 0, 0, 0);
    queue_tables(1, 64, 0, 0, 0);
    queue_row(1, 0);
    drain();

    // Random phases with small sizes and random content and noise.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 67; recv_idle = 29; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      nc = $urandom_range(1, 3); no = $urandom_range(1, 3);
      nr = $urandom_range(1, 3); b = $urandom_range(1); t = $urandom_range(1);
      setup(nc, no, nr, b, t);
      queue_tables(nc, no, t, b, 0);
      for (int r = 0; r < 3; r++) begin
        queue_row(nc, 0);
        if ($urandom_range(3) == 0)
          pending_items.push_back(mk(2'd3, $urandom_range(63), $urandom_range(63),
                                     16'($urandom)));
      end
      drain();
    end

    $display("%0d transactions in, %0d results out over %0d rows", n_items, n_results,
             n_rows);
    $display("covered bias on/off, both weight layouts, 64 outputs, operand extremes");
    if (!failed)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
